// ===== hw/rtl/rfcb_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rfcb_pkg
// Shared types and codes for the rectangle fill / copy blitter.
// -----------------------------------------------------------------------------
package rfcb_pkg;

	localparam int unsigned POS_W      = 6;   // pixel column / line
	localparam int unsigned DIM_W      = 7;   // sizes, line width, line count
	localparam int unsigned PIX_W      = 32;  // pixel word
	localparam int unsigned LA_W       = 14;  // linear address y*W+x, W,H <= 127
	localparam int unsigned OP_W       = 2;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 7;

	localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
	localparam logic [OP_W-1:0] OP_COPY  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_REFUSED = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NOTHING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RUNNING    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd2;

	typedef logic [LA_W-1:0] lin_addr_t;

	typedef struct packed {
		logic             running;
		logic [DIM_W-1:0] width;   // clamped to MAX_DIM
		logic [DIM_W-1:0] height;  // clamped to MAX_DIM
	} geom_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic             raster_op;
		logic [POS_W-1:0] dest_x;
		logic [POS_W-1:0] dest_y;
		logic [POS_W-1:0] source_x;
		logic [POS_W-1:0] source_y;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
		logic [PIX_W-1:0] color;
	} cmd_t;

	typedef struct packed {
		logic re;
		logic we;
	} mem_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rfcb_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rfcb_ram
// Generic single-port RAM, one access per cycle, registered read data.
// -----------------------------------------------------------------------------
module rfcb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             re,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rfcb_regs.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rfcb_regs
// Configuration registers and geometry clamp to MAX_DIM.
// -----------------------------------------------------------------------------
module rfcb_regs #(
	parameter int unsigned MAX_DIM = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [rfcb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rfcb_pkg::CFG_DATA_W-1:0]    cfg_data,
	output rfcb_pkg::geom_t                         geom
);

	localparam int unsigned DW     = rfcb_pkg::DIM_W;
	localparam int unsigned DimCap = (MAX_DIM < 127) ? MAX_DIM : 127;
	localparam logic [DW-1:0] CAP  = DW'(DimCap);

	logic          running_q;
	logic [DW-1:0] line_width_q;
	logic [DW-1:0] line_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b1;
			line_width_q <= DW'(64);
			line_count_q <= DW'(64);
		end else if (cfg_write) begin
			unique case (cfg_index)
				rfcb_pkg::REG_RUNNING:    running_q    <= cfg_data[0];
				rfcb_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[DW-1:0];
				rfcb_pkg::REG_LINE_COUNT: line_count_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	assign geom.running = running_q;
	assign geom.width   = (line_width_q > CAP) ? CAP : line_width_q;
	assign geom.height  = (line_count_q > CAP) ? CAP : line_count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rfcb_seq.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rfcb_seq
// Command sequencer: clip, address unit (one multiply-add shared by the
// destination and source start), pixel walker over the single-port store.
// -----------------------------------------------------------------------------
module rfcb_seq #(
	parameter int unsigned FRAME_WORDS = 4096,
	localparam int unsigned AW         = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire rfcb_pkg::cmd_t                  cmd,
	input  wire rfcb_pkg::geom_t                 geom,
	output rfcb_pkg::mem_ctl_t                   mem_ctl,
	output logic      [AW-1:0]                   mem_addr,
	output logic      [rfcb_pkg::PIX_W-1:0]      mem_wdata,
	input  wire logic [rfcb_pkg::PIX_W-1:0]      mem_rdata,
	output logic                                 done,
	output logic      [rfcb_pkg::PIX_W-1:0]      read_data,
	output logic      [rfcb_pkg::STAT_W-1:0]     status
);

	localparam int unsigned DW = rfcb_pkg::DIM_W;
	localparam int unsigned LW = rfcb_pkg::LA_W;
	localparam int unsigned PW = rfcb_pkg::PIX_W;
	localparam int unsigned XW = (AW > LW) ? AW : LW;
	localparam logic [AW-1:0] CLR_LAST = AW'(FRAME_WORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_ADDR_D,
		S_ADDR_S,
		S_RD,
		S_WR,
		S_RESP
	} state_t;

	function automatic logic in_store(input rfcb_pkg::lin_addr_t a);
		in_store = 32'(a) < 32'(FRAME_WORDS);
	endfunction

	function automatic logic [AW-1:0] to_idx(input rfcb_pkg::lin_addr_t a);
		logic [XW-1:0] t;
		t      = XW'(a);
		to_idx = t[AW-1:0];
	endfunction

	state_t                      state_q;
	logic [AW-1:0]               clr_q;
	logic                        done_q;
	logic [PW-1:0]               read_data_q;
	logic [rfcb_pkg::STAT_W-1:0] status_q;

	rfcb_pkg::cmd_t              cmd_q;
	logic [DW-1:0]               cw_q, ch_q, c_q, r_q;
	logic                        bwd_q;
	logic                        oob_q;
	rfcb_pkg::lin_addr_t         da_q, drow_q, sa_q, srow_q;

	// geometry / clip
	logic [DW-1:0] dx_e, dy_e, sx_e, sy_e;
	logic          dst_off, src_off, is_copy, needs_read;
	logic [DW-1:0] room_dx, room_dy, room_sx, room_sy, w1, h1, cw_n, ch_n;
	logic          bwd_n;

	assign dx_e    = {1'b0, cmd_q.dest_x};
	assign dy_e    = {1'b0, cmd_q.dest_y};
	assign sx_e    = {1'b0, cmd_q.source_x};
	assign sy_e    = {1'b0, cmd_q.source_y};
	assign dst_off = (dx_e >= geom.width) || (dy_e >= geom.height);
	assign src_off = (sx_e >= geom.width) || (sy_e >= geom.height);
	assign is_copy = cmd_q.op == rfcb_pkg::OP_COPY;
	assign needs_read = is_copy || (cmd_q.op == rfcb_pkg::OP_READ)
		|| ((cmd_q.op == rfcb_pkg::OP_FILL) && cmd_q.raster_op);

	assign room_dx = geom.width - dx_e;
	assign room_dy = geom.height - dy_e;
	assign room_sx = geom.width - sx_e;
	assign room_sy = geom.height - sy_e;
	assign w1      = (cmd_q.rect_width > room_dx) ? room_dx : cmd_q.rect_width;
	assign h1      = (cmd_q.rect_height > room_dy) ? room_dy : cmd_q.rect_height;
	assign cw_n    = (is_copy && (w1 > room_sx)) ? room_sx : w1;
	assign ch_n    = (is_copy && (h1 > room_sy)) ? room_sy : h1;
	// dest after source in linear order: walk backward so source is read before overwrite
	assign bwd_n   = is_copy && ((dy_e > sy_e) || ((dy_e == sy_e) && (dx_e > sx_e)));

	// shared address unit: start = y*W + x, at the far corner when walking backward
	logic [DW-1:0]       ay, ax, ay2, ax2;
	rfcb_pkg::lin_addr_t addr_calc;

	assign ay        = (state_q == S_ADDR_S) ? sy_e : dy_e;
	assign ax        = (state_q == S_ADDR_S) ? sx_e : dx_e;
	assign ay2       = bwd_q ? DW'(ay + ch_q - DW'(1)) : ay;
	assign ax2       = bwd_q ? DW'(ax + cw_q - DW'(1)) : ax;
	assign addr_calc = LW'(LW'(ay2) * LW'(geom.width)) + LW'(ax2);

	// pixel walk
	logic                last_col, last_row;
	rfcb_pkg::lin_addr_t step_w, drow_n, srow_n, da_n, sa_n, rd_addr;
	logic [PW-1:0]       rdv, wr_data;

	assign last_col = c_q == (cw_q - DW'(1));
	assign last_row = r_q == (ch_q - DW'(1));
	assign step_w   = LW'(geom.width);
	assign drow_n   = bwd_q ? drow_q - step_w : drow_q + step_w;
	assign srow_n   = bwd_q ? srow_q - step_w : srow_q + step_w;
	assign da_n     = bwd_q ? da_q - LW'(1) : da_q + LW'(1);
	assign sa_n     = bwd_q ? sa_q - LW'(1) : sa_q + LW'(1);
	assign rd_addr  = is_copy ? sa_q : da_q;
	assign rdv      = oob_q ? '0 : mem_rdata;

	always_comb begin
		priority if (is_copy) begin
			wr_data = rdv;
		end else if ((cmd_q.op == rfcb_pkg::OP_FILL) && cmd_q.raster_op) begin
			wr_data = rdv ^ cmd_q.color;
		end else begin
			wr_data = cmd_q.color;
		end
	end

	always_comb begin
		mem_ctl.re = 1'b0;
		mem_ctl.we = 1'b0;
		mem_addr   = to_idx(da_q);
		mem_wdata  = wr_data;
		unique case (state_q)
			S_CLEAR: begin
				mem_ctl.we = 1'b1;
				mem_addr   = clr_q;
				mem_wdata  = '0;
			end
			S_RD: begin
				mem_ctl.re = in_store(rd_addr);
				mem_addr   = to_idx(rd_addr);
			end
			S_WR: begin
				mem_ctl.we = in_store(da_q);
			end
			default: ;
		endcase
	end

	// control and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			done_q      <= 1'b0;
			read_data_q <= '0;
			status_q    <= rfcb_pkg::STATUS_DONE;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					priority if (!geom.running) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						read_data_q <= '0;
						status_q    <= rfcb_pkg::STATUS_REFUSED;
					end else if (dst_off) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						read_data_q <= '0;
						status_q    <= rfcb_pkg::STATUS_NOTHING;
					end else if (cmd_q.op == rfcb_pkg::OP_WRITE
						|| cmd_q.op == rfcb_pkg::OP_READ) begin
						state_q <= S_ADDR_D;
					end else if (cmd_q.rect_width == '0 || cmd_q.rect_height == '0
						|| (is_copy && src_off)) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						read_data_q <= '0;
						status_q    <= rfcb_pkg::STATUS_NOTHING;
					end else begin
						state_q <= S_ADDR_D;
					end
				end
				S_ADDR_D: begin
					priority if (is_copy) begin
						state_q <= S_ADDR_S;
					end else if (needs_read) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_WR;
					end
				end
				S_ADDR_S: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= (cmd_q.op == rfcb_pkg::OP_READ) ? S_RESP : S_WR;
				end
				S_RESP: begin
					state_q     <= S_IDLE;
					done_q      <= 1'b1;
					read_data_q <= rdv;
					status_q    <= rfcb_pkg::STATUS_DONE;
				end
				S_WR: begin
					if (last_col && last_row) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						read_data_q <= '0;
						status_q    <= rfcb_pkg::STATUS_DONE;
					end else begin
						state_q <= needs_read ? S_RD : S_WR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
				end
			end
			S_SETUP: begin
				c_q <= '0;
				r_q <= '0;
				if (cmd_q.op == rfcb_pkg::OP_WRITE || cmd_q.op == rfcb_pkg::OP_READ) begin
					cw_q  <= DW'(1);
					ch_q  <= DW'(1);
					bwd_q <= 1'b0;
				end else begin
					cw_q  <= cw_n;
					ch_q  <= ch_n;
					bwd_q <= bwd_n;
				end
			end
			S_ADDR_D: begin
				da_q   <= addr_calc;
				drow_q <= addr_calc;
			end
			S_ADDR_S: begin
				sa_q   <= addr_calc;
				srow_q <= addr_calc;
			end
			S_RD: begin
				oob_q <= !in_store(rd_addr);
			end
			S_WR: begin
				if (last_col) begin
					c_q    <= '0;
					r_q    <= r_q + DW'(1);
					drow_q <= drow_n;
					da_q   <= drow_n;
					srow_q <= srow_n;
					sa_q   <= srow_n;
				end else begin
					c_q  <= c_q + DW'(1);
					da_q <= da_n;
					sa_q <= sa_n;
				end
			end
			default: ;
		endcase
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.we |-> (state_q == S_CLEAR || state_q == S_WR))
		else $error("store write outside clear or write step");

	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && read_data_q != '0) |-> (status_q == rfcb_pkg::STATUS_DONE))
		else $error("read data on a failed command");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_SETUP))
		else $error("accepted command did not enter setup");

	a_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && last_col && last_row) |=> done_q)
		else $error("last pixel without result");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/rect_fill_and_copy_blitter_core.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rect_fill_and_copy_blitter_core
// 2D blitter over a 32-bit pixel frame store: fill (overwrite / XOR),
// copy area, write pixel, read pixel, clipped to the virtual geometry.
// -----------------------------------------------------------------------------
// channel   handshake                 word
// command   start, busy               op .. color, taken when start & !busy
// result    done (one-cycle strobe)   read_data, status
// config    cfg_write                 cfg_index, cfg_data (no wait)
//
// After reset the store is cleared, one word a cycle, while busy stays high.
// A command runs setup and destination address steps (copy adds a source
// address step, running the shared multiply-add again), then per pixel a
// write step for overwrite fill and write pixel, or a read and a write step
// for XOR fill and copy, set by the single store port; read pixel runs setup,
// destination address, read and response steps. The result strobe follows in
// the next cycle. The receiver cannot stall; one command is in flight at a time.
// -----------------------------------------------------------------------------
module rect_fill_and_copy_blitter_core #(
	parameter int unsigned FRAME_WORDS = 4096,
	parameter int unsigned MAX_DIM     = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [rfcb_pkg::OP_W-1:0]        op,
	input  wire logic                             raster_op,
	input  wire logic [rfcb_pkg::POS_W-1:0]       dest_x,
	input  wire logic [rfcb_pkg::POS_W-1:0]       dest_y,
	input  wire logic [rfcb_pkg::POS_W-1:0]       source_x,
	input  wire logic [rfcb_pkg::POS_W-1:0]       source_y,
	input  wire logic [rfcb_pkg::DIM_W-1:0]       rect_width,
	input  wire logic [rfcb_pkg::DIM_W-1:0]       rect_height,
	input  wire logic [rfcb_pkg::PIX_W-1:0]       color,
	output logic                                  done,
	output logic      [rfcb_pkg::PIX_W-1:0]       read_data,
	output logic      [rfcb_pkg::STAT_W-1:0]      status,
	input  wire logic                             cfg_write,
	input  wire logic [rfcb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rfcb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

	rfcb_pkg::cmd_t              cmd;
	rfcb_pkg::geom_t             geom;
	rfcb_pkg::mem_ctl_t          mem_ctl;
	logic [AW-1:0]               mem_addr;
	logic [rfcb_pkg::PIX_W-1:0]  mem_wdata;
	logic [rfcb_pkg::PIX_W-1:0]  mem_rdata;

	assign cmd.op          = op;
	assign cmd.raster_op   = raster_op;
	assign cmd.dest_x      = dest_x;
	assign cmd.dest_y      = dest_y;
	assign cmd.source_x    = source_x;
	assign cmd.source_y    = source_y;
	assign cmd.rect_width  = rect_width;
	assign cmd.rect_height = rect_height;
	assign cmd.color       = color;

	rfcb_regs #(
		.MAX_DIM (MAX_DIM)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	rfcb_seq #(
		.FRAME_WORDS (FRAME_WORDS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.geom      (geom),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.done      (done),
		.read_data (read_data),
		.status    (status)
	);

	rfcb_ram #(
		.WIDTH (rfcb_pkg::PIX_W),
		.DEPTH (FRAME_WORDS)
	) u_frame (
		.clk   (clk),
		.re    (mem_ctl.re),
		.we    (mem_ctl.we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire
